[rtl/core/rmvn_pkg.sv]
// Shared types, constants and helpers of the running mean/variance normalizer.
package rmvn_pkg;

  localparam int OBS_DIM = 64;
  localparam int AW = (OBS_DIM > 1) ? $clog2(OBS_DIM) : 1;

  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam logic [31:0] VAR_RESET = 32'h0001_0000;

  localparam int SQRT_STEPS = 24;
  localparam int DIV_STEPS = 49;

  localparam logic [2:0] REG_OBS_SMOOTH = 3'd0;
  localparam logic [2:0] REG_REW_SMOOTH = 3'd1;
  localparam logic [2:0] REG_OBS_EN = 3'd2;
  localparam logic [2:0] REG_REW_EN = 3'd3;
  localparam logic [2:0] REG_REW_GAIN = 3'd4;

  typedef struct packed {
    logic [16:0] obs_smooth;
    logic [16:0] rew_smooth;
    logic        obs_en;
    logic        rew_en;
    logic [24:0] gain;
  } cfg_t;

  typedef enum logic [2:0] {
    MS_MEAN_OLD,
    MS_SAMPLE,
    MS_DEV,
    MS_VAR_OLD,
    MS_VAR_NEW,
    MS_GAIN_LO,
    MS_GAIN_HI
  } mul_sel_e;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_LOAD,
    ACC_ADD,
    ACC_ADD_HI
  } acc_op_e;

  typedef struct packed {
    logic     load_item;
    mul_sel_e mul_sel;
    acc_op_e  acc_op;
    logic     lat_mean;
    logic     lat_dev;
    logic     lat_sq;
    logic     lat_var;
    logic     write_back;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     div_init;
    logic     div_step;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic op;
    logic norm;
  } sts_t;

  function automatic logic [31:0] sat32(input logic neg, input logic [59:0] mag);
    logic [31:0] res;
    if (neg) begin
      if (mag > 60'h0_8000_0000) res = 32'h8000_0000;
      else res = ~mag[31:0] + 32'd1;
    end else begin
      if (mag > 60'h0_7FFF_FFFF) res = 32'h7FFF_FFFF;
      else res = mag[31:0];
    end
    return res;
  endfunction

endpackage

[rtl/core/rmvn_ctrl.sv]
// Sequencing state machine of the normalizer.
module rmvn_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  logic          out_ready_i,
  output logic          out_valid_o,
  input  rmvn_pkg::sts_t sts_i,
  output rmvn_pkg::cmd_t cmd_o
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_FETCH = 5'd1;
  localparam logic [4:0] S_M1    = 5'd2;
  localparam logic [4:0] S_M2    = 5'd3;
  localparam logic [4:0] S_M3    = 5'd4;
  localparam logic [4:0] S_M4    = 5'd5;
  localparam logic [4:0] S_M5    = 5'd6;
  localparam logic [4:0] S_M6    = 5'd7;
  localparam logic [4:0] S_M7    = 5'd8;
  localparam logic [4:0] S_M8    = 5'd9;
  localparam logic [4:0] S_M9    = 5'd10;
  localparam logic [4:0] S_M10   = 5'd11;
  localparam logic [4:0] S_M11   = 5'd12;
  localparam logic [4:0] S_M12   = 5'd13;
  localparam logic [4:0] S_WB    = 5'd14;
  localparam logic [4:0] S_SQRT  = 5'd15;
  localparam logic [4:0] S_DIVI  = 5'd16;
  localparam logic [4:0] S_DIV   = 5'd17;
  localparam logic [4:0] S_G1    = 5'd18;
  localparam logic [4:0] S_G2    = 5'd19;
  localparam logic [4:0] S_G3    = 5'd20;
  localparam logic [4:0] S_DONE  = 5'd21;

  logic [4:0] state_q, state_d;
  logic [5:0] cnt_q, cnt_d;
  logic       out_valid_q, out_valid_d;
  logic       slot_free;

  assign slot_free   = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.mul_sel = rmvn_pkg::MS_MEAN_OLD;
    cmd_o.acc_op  = rmvn_pkg::ACC_HOLD;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_item = 1'b1;
          state_d = S_FETCH;
        end
      end
      S_FETCH: begin
        if (sts_i.norm) state_d = S_M1;
        else if (sts_i.op) state_d = S_G1;
        else state_d = S_DONE;
      end
      S_M1: begin
        cmd_o.mul_sel = rmvn_pkg::MS_MEAN_OLD;
        state_d = S_M2;
      end
      S_M2: begin
        cmd_o.mul_sel = rmvn_pkg::MS_SAMPLE;
        cmd_o.acc_op  = rmvn_pkg::ACC_LOAD;
        state_d = S_M3;
      end
      S_M3: begin
        cmd_o.acc_op = rmvn_pkg::ACC_ADD;
        state_d = S_M4;
      end
      S_M4: begin
        cmd_o.lat_mean = 1'b1;
        state_d = S_M5;
      end
      S_M5: begin
        cmd_o.lat_dev = 1'b1;
        state_d = S_M6;
      end
      S_M6: begin
        cmd_o.mul_sel = rmvn_pkg::MS_DEV;
        state_d = S_M7;
      end
      S_M7: begin
        cmd_o.acc_op = rmvn_pkg::ACC_LOAD;
        state_d = S_M8;
      end
      S_M8: begin
        cmd_o.lat_sq = 1'b1;
        state_d = S_M9;
      end
      S_M9: begin
        cmd_o.mul_sel = rmvn_pkg::MS_VAR_OLD;
        state_d = S_M10;
      end
      S_M10: begin
        cmd_o.mul_sel = rmvn_pkg::MS_VAR_NEW;
        cmd_o.acc_op  = rmvn_pkg::ACC_LOAD;
        state_d = S_M11;
      end
      S_M11: begin
        cmd_o.acc_op = rmvn_pkg::ACC_ADD;
        state_d = S_M12;
      end
      S_M12: begin
        cmd_o.lat_var = 1'b1;
        state_d = S_WB;
      end
      S_WB: begin
        cmd_o.write_back = 1'b1;
        cmd_o.sqrt_init  = 1'b1;
        cnt_d = '0;
        state_d = S_SQRT;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(rmvn_pkg::SQRT_STEPS - 1)) state_d = S_DIVI;
      end
      S_DIVI: begin
        cmd_o.div_init = 1'b1;
        cnt_d = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(rmvn_pkg::DIV_STEPS - 1)) state_d = sts_i.op ? S_G1 : S_DONE;
      end
      S_G1: begin
        cmd_o.mul_sel = rmvn_pkg::MS_GAIN_LO;
        state_d = S_G2;
      end
      S_G2: begin
        cmd_o.mul_sel = rmvn_pkg::MS_GAIN_HI;
        cmd_o.acc_op  = rmvn_pkg::ACC_LOAD;
        state_d = S_G3;
      end
      S_G3: begin
        cmd_o.acc_op = rmvn_pkg::ACC_ADD_HI;
        state_d = S_DONE;
      end
      S_DONE: begin
        if (slot_free) begin
          cmd_o.finish = 1'b1;
          out_valid_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> state_q == S_FETCH)
    else $error("accepted item did not start processing");

  a_finish_needs_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> slot_free)
    else $error("result overwrites a pending output");

  a_single_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.load_item, cmd_o.write_back, cmd_o.div_init, cmd_o.finish}))
    else $error("conflicting datapath commands");

  a_finish_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> out_valid_o)
    else $error("finished result not presented");

endmodule

[rtl/core/rmvn_dp.sv]
// Datapath of the normalizer: statistics store, multiply-accumulate, root and divider.
module rmvn_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  rmvn_pkg::cfg_t        cfg_i,
  input  rmvn_pkg::cmd_t        cmd_i,
  output rmvn_pkg::sts_t        sts_o,
  input  logic                  in_op_i,
  input  logic [5:0]            in_idx_i,
  input  logic signed [31:0]    in_sample_i,
  output logic [31:0]           out_norm_o,
  output logic                  out_kind_o,
  output logic [5:0]            out_elem_o
);

  localparam int AW = rmvn_pkg::AW;

  logic [31:0] mean_mem [rmvn_pkg::OBS_DIM];
  logic [31:0] var_mem [rmvn_pkg::OBS_DIM];
  logic [rmvn_pkg::OBS_DIM-1:0] vld_q;
  logic [31:0] mrd_mean_q, mrd_var_q;

  logic signed [31:0] x_q;
  logic               op_q;
  logic [5:0]         idx_q;
  logic signed [31:0] rmean_q;
  logic [31:0]        rvar_q;

  logic [AW+5:0] in_idx_ext, idx_ext;
  logic [AW-1:0] in_addr, addr;
  logic          in_range;

  logic [16:0] sm, a, ia;
  logic signed [31:0] mean_cur;
  logic [31:0]        var_cur;
  logic [31:0]        xmag;
  logic [48:0]        gmag;

  logic signed [32:0] opa, opb;
  logic signed [65:0] prod_q;
  logic signed [75:0] acc_q, prod_ext, rnd, rsh;
  logic [31:0]        rsh_sat;

  logic signed [31:0] m_q;
  logic [31:0]        dmag_q, sq_q, v_q;
  logic               dneg_q;
  logic signed [32:0] dev;

  logic [47:0] rad_q;
  logic [26:0] srem_q, strem, strial;
  logic [23:0] root_q, r_q;
  logic [48:0] num_q, q_q;
  logic [24:0] drem_q, dtrem;
  logic [31:0] dsrc;

  assign in_idx_ext = {{AW{1'b0}}, in_idx_i};
  assign in_addr    = in_idx_ext[AW-1:0];
  assign idx_ext    = {{AW{1'b0}}, idx_q};
  assign addr       = idx_ext[AW-1:0];
  assign in_range   = idx_ext < (AW+6)'(rmvn_pkg::OBS_DIM);

  assign sts_o.op   = op_q;
  assign sts_o.norm = op_q ? cfg_i.rew_en : (cfg_i.obs_en && in_range);

  assign sm = op_q ? cfg_i.rew_smooth : cfg_i.obs_smooth;
  assign a  = (sm > rmvn_pkg::ONE_Q16) ? rmvn_pkg::ONE_Q16 : sm;
  assign ia = rmvn_pkg::ONE_Q16 - a;

  assign mean_cur = op_q ? rmean_q : (vld_q[addr] ? $signed(mrd_mean_q) : 32'sd0);
  assign var_cur  = op_q ? rvar_q : (vld_q[addr] ? mrd_var_q : rmvn_pkg::VAR_RESET);
  assign xmag     = x_q[31] ? (~x_q + 32'd1) : x_q;
  assign gmag     = sts_o.norm ? q_q : {17'd0, xmag};

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (cmd_i.mul_sel)
      rmvn_pkg::MS_MEAN_OLD: begin opa = {16'd0, ia}; opb = {mean_cur[31], mean_cur}; end
      rmvn_pkg::MS_SAMPLE:   begin opa = {16'd0, a};  opb = {x_q[31], x_q}; end
      rmvn_pkg::MS_DEV:      begin opa = {1'b0, dmag_q}; opb = {1'b0, dmag_q}; end
      rmvn_pkg::MS_VAR_OLD:  begin opa = {16'd0, ia}; opb = {1'b0, var_cur}; end
      rmvn_pkg::MS_VAR_NEW:  begin opa = {16'd0, a};  opb = {1'b0, sq_q}; end
      rmvn_pkg::MS_GAIN_LO:  begin opa = {1'b0, gmag[31:0]}; opb = {8'd0, cfg_i.gain}; end
      rmvn_pkg::MS_GAIN_HI:  begin opa = {16'd0, gmag[48:32]}; opb = {8'd0, cfg_i.gain}; end
      default:               begin opa = '0; opb = '0; end
    endcase
  end

  assign prod_ext = {{10{prod_q[65]}}, prod_q};
  assign rnd      = acc_q + 76'sd32768;
  assign rsh      = rnd >>> 16;
  assign rsh_sat  = (rsh[75:32] != '0) ? 32'hFFFF_FFFF : rsh[31:0];
  assign dev      = {x_q[31], x_q} - {m_q[31], m_q};

  assign strem  = {srem_q[24:0], rad_q[47:46]};
  assign strial = {1'b0, root_q, 2'b01};
  assign dtrem  = {drem_q[23:0], num_q[48]};
  assign dsrc   = op_q ? xmag : dmag_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      mrd_mean_q <= mean_mem[in_addr];
      mrd_var_q  <= var_mem[in_addr];
    end
    if (cmd_i.write_back && !op_q) begin
      mean_mem[addr] <= m_q;
      var_mem[addr]  <= v_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      rmean_q <= '0;
      rvar_q  <= rmvn_pkg::VAR_RESET;
    end else if (cmd_i.write_back) begin
      if (op_q) begin
        rmean_q <= m_q;
        rvar_q  <= v_q;
      end else begin
        vld_q[addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_item) begin
      x_q   <= in_sample_i;
      op_q  <= in_op_i;
      idx_q <= in_idx_i;
    end
    prod_q <= opa * opb;
    unique case (cmd_i.acc_op)
      rmvn_pkg::ACC_HOLD:   acc_q <= acc_q;
      rmvn_pkg::ACC_LOAD:   acc_q <= prod_ext;
      rmvn_pkg::ACC_ADD:    acc_q <= acc_q + prod_ext;
      rmvn_pkg::ACC_ADD_HI: acc_q <= acc_q + (prod_ext <<< 32);
      default:              acc_q <= acc_q;
    endcase
    if (cmd_i.lat_mean) m_q <= rsh[31:0];
    if (cmd_i.lat_dev) begin
      dneg_q <= dev[32];
      dmag_q <= dev[32] ? 32'(-dev) : dev[31:0];
    end
    if (cmd_i.lat_sq) sq_q <= rsh_sat;
    if (cmd_i.lat_var) v_q <= rsh_sat;
    if (cmd_i.sqrt_init) begin
      rad_q  <= {v_q, 16'd0};
      srem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[45:0], 2'b00};
      if (strem >= strial) begin
        srem_q <= strem - strial;
        root_q <= {root_q[22:0], 1'b1};
      end else begin
        srem_q <= strem;
        root_q <= {root_q[22:0], 1'b0};
      end
    end
    if (cmd_i.div_init) begin
      r_q    <= (root_q == '0) ? 24'd1 : root_q;
      num_q  <= {1'b0, dsrc, 16'd0} + {25'd0, ((root_q == '0) ? 24'd1 : root_q) >> 1};
      drem_q <= '0;
      q_q    <= '0;
    end else if (cmd_i.div_step) begin
      num_q <= {num_q[47:0], 1'b0};
      if (dtrem >= {1'b0, r_q}) begin
        drem_q <= dtrem - {1'b0, r_q};
        q_q    <= {q_q[47:0], 1'b1};
      end else begin
        drem_q <= dtrem;
        q_q    <= {q_q[47:0], 1'b0};
      end
    end
    if (cmd_i.finish) begin
      out_kind_o <= op_q;
      out_elem_o <= op_q ? 6'd0 : idx_q;
      if (op_q) out_norm_o <= rmvn_pkg::sat32(x_q[31], rsh[59:0]);
      else if (sts_o.norm) out_norm_o <= rmvn_pkg::sat32(dneg_q, {11'd0, q_q});
      else out_norm_o <= x_q;
    end
  end

endmodule

[rtl/core/running_mean_variance_normalizer_core.sv]
// Top level of the running mean/variance normalizer: configuration registers and core.
//
//  channel   dir  handshake                      content
//  s_axis    in   s_axis_tvalid_i/tready_o       tdata: element_index, sample_in; tuser: op
//  m_axis    out  m_axis_tvalid_o/tready_i       tdata: normalized_out, element_out; tuser: kind
//  cfg       in   cfg_we_i                       cfg_index_i selects register, cfg_wdata_i
//
// Normalized items go through the 24-step root and the 49-step divider, one bit a cycle;
// pass-through items skip both, and rewards of either kind then pass the gain multiply.
// Reset clears valid bits of the statistics store at once; no clearing pass.
// A waiting result holds in the output register while the next item is processed.
module running_mean_variance_normalizer_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [39:0] s_axis_tdata_i,   // [5:0] element_index, [37:6] sample_in, zero pad
  input  logic        s_axis_tuser_i,   // [0] op
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [39:0] m_axis_tdata_o,   // [31:0] normalized_out, [37:32] element_out, zero pad
  output logic        m_axis_tuser_o,   // [0] kind_out
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [24:0] cfg_wdata_i
);

  rmvn_pkg::cfg_t cfg_q;
  rmvn_pkg::cmd_t cmd;
  rmvn_pkg::sts_t sts;
  logic [31:0] out_norm;
  logic [5:0]  out_elem;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.obs_smooth <= 17'd66;
      cfg_q.rew_smooth <= 17'd66;
      cfg_q.obs_en     <= 1'b0;
      cfg_q.rew_en     <= 1'b0;
      cfg_q.gain       <= 25'd65536;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        rmvn_pkg::REG_OBS_SMOOTH: cfg_q.obs_smooth <= cfg_wdata_i[16:0];
        rmvn_pkg::REG_REW_SMOOTH: cfg_q.rew_smooth <= cfg_wdata_i[16:0];
        rmvn_pkg::REG_OBS_EN:     cfg_q.obs_en     <= cfg_wdata_i[0];
        rmvn_pkg::REG_REW_EN:     cfg_q.rew_en     <= cfg_wdata_i[0];
        rmvn_pkg::REG_REW_GAIN:   cfg_q.gain       <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  rmvn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_ready_i (m_axis_tready_i),
    .out_valid_o (m_axis_tvalid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rmvn_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_op_i     (s_axis_tuser_i),
    .in_idx_i    (s_axis_tdata_i[5:0]),
    .in_sample_i (s_axis_tdata_i[37:6]),
    .out_norm_o  (out_norm),
    .out_kind_o  (m_axis_tuser_o),
    .out_elem_o  (out_elem)
  );

  assign m_axis_tdata_o = {2'b00, out_elem, out_norm};

endmodule

[tb/sv/rmvn_monitor.sv]
// Watches the normalizer channels, predicts every result and compares it.
module rmvn_monitor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [39:0] s_tdata_i,   // [5:0] element_index, [37:6] sample_in, zero pad
  input  logic        s_tuser_i,   // [0] op
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,   // [31:0] normalized_out, [37:32] element_out, zero pad
  input  logic        m_tuser_i,   // [0] kind_out
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [24:0] cfg_wdata_i,
  output int          fail_count_o,
  output int          pending_o
);

  typedef struct packed {
    logic [31:0] value;
    logic        kind;
    logic [5:0]  element;
  } norm_result_t;

  norm_result_t expected_results[$];

  logic signed [31:0] obs_mean [rmvn_pkg::OBS_DIM];
  logic [31:0]        obs_var  [rmvn_pkg::OBS_DIM];
  logic signed [31:0] rew_mean;
  logic [31:0]        rew_var;
  rmvn_pkg::cfg_t     cfg;

  assign pending_o = expected_results.size();

  function automatic logic [16:0] clamp_alpha(logic [16:0] a);
    return (a > 17'd65536) ? 17'd65536 : a;
  endfunction

  function automatic logic signed [31:0] ema_mean(logic signed [31:0] mean,
                                                  logic signed [31:0] x, logic [16:0] a);
    longint s, r, am;
    am = 65536 - longint'(a);
    s = am * longint'(mean) + longint'(a) * longint'(x);
    r = (s + 32768) >>> 16;
    if (r > 64'sd2147483647) r = 64'sd2147483647;
    if (r < -64'sd2147483648) r = -64'sd2147483648;
    return r[31:0];
  endfunction

  function automatic logic [31:0] ema_var(logic [31:0] v, logic signed [31:0] x,
                                          logic signed [31:0] mean, logic [16:0] a);
    longint d;
    logic [63:0] m, sq, s;
    d = longint'(x) - longint'(mean);
    m = (d < 0) ? -d : d;
    sq = (m * m + 64'd32768) >> 16;
    if (sq > 64'hFFFF_FFFF) sq = 64'hFFFF_FFFF;
    s = (64'd65536 - 64'(a)) * 64'(v) + 64'(a) * sq;
    s = (s + 64'd32768) >> 16;
    if (s > 64'hFFFF_FFFF) s = 64'hFFFF_FFFF;
    return s[31:0];
  endfunction

  function automatic logic [63:0] root_q16(logic [31:0] v);
    logic [63:0] n, res, b;
    n = {16'd0, v, 16'd0};
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n = n - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    return (res == 0) ? 64'd1 : res;
  endfunction

  function automatic logic [63:0] div_mag(logic [63:0] mag, logic [63:0] r);
    return ((mag << 16) + (r >> 1)) / r;
  endfunction

  function automatic logic [63:0] apply_gain(logic [63:0] mag, logic [24:0] g);
    logic [127:0] p;
    p = {64'd0, mag} * {103'd0, g};
    if (p > 128'hFFFF_FFFF_FFFF_FFFF - 128'd32768) return 64'hFFFF_FFFF_FFFF_FFFF;
    p = (p + 128'd32768) >> 16;
    return p[63:0];
  endfunction

  function automatic logic [31:0] saturate32(logic neg, logic [63:0] mag);
    if (neg) begin
      if (mag > 64'h8000_0000) mag = 64'h8000_0000;
      return 32'd0 - mag[31:0];
    end
    if (mag > 64'h7FFF_FFFF) mag = 64'h7FFF_FFFF;
    return mag[31:0];
  endfunction

  task automatic predict_normalized(logic op, logic [5:0] idx, logic signed [31:0] x);
    norm_result_t res;
    logic [16:0] a;
    logic signed [31:0] m;
    logic [31:0] v;
    longint d;
    logic [63:0] mag;
    res.kind = op;
    mag = (x < 0) ? -longint'(x) : longint'(x);
    if (!op) begin
      res.element = idx;
      if (cfg.obs_en && idx < rmvn_pkg::OBS_DIM) begin
        a = clamp_alpha(cfg.obs_smooth);
        m = ema_mean(obs_mean[idx], x, a);
        v = ema_var(obs_var[idx], x, m, a);
        obs_mean[idx] = m;
        obs_var[idx] = v;
        d = longint'(x) - longint'(m);
        res.value = saturate32(d < 0, div_mag((d < 0) ? -d : d, root_q16(v)));
      end else begin
        res.value = x;
      end
    end else begin
      res.element = 6'd0;
      if (cfg.rew_en) begin
        a = clamp_alpha(cfg.rew_smooth);
        rew_mean = ema_mean(rew_mean, x, a);
        rew_var = ema_var(rew_var, x, rew_mean, a);
        mag = div_mag(mag, root_q16(rew_var));
      end
      res.value = saturate32(x < 0, apply_gain(mag, cfg.gain));
    end
    expected_results.push_back(res);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    norm_result_t exp_r;
    if (!rst_ni) begin
      for (int i = 0; i < rmvn_pkg::OBS_DIM; i++) begin
        obs_mean[i] = 0;
        obs_var[i] = rmvn_pkg::VAR_RESET;
      end
      rew_mean = 0;
      rew_var = rmvn_pkg::VAR_RESET;
      cfg = '{obs_smooth: 17'd66, rew_smooth: 17'd66, obs_en: 1'b0, rew_en: 1'b0,
              gain: 25'd65536};
      fail_count_o = 0;
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          rmvn_pkg::REG_OBS_SMOOTH: cfg.obs_smooth = cfg_wdata_i[16:0];
          rmvn_pkg::REG_REW_SMOOTH: cfg.rew_smooth = cfg_wdata_i[16:0];
          rmvn_pkg::REG_OBS_EN:     cfg.obs_en = cfg_wdata_i[0];
          rmvn_pkg::REG_REW_EN:     cfg.rew_en = cfg_wdata_i[0];
          rmvn_pkg::REG_REW_GAIN:   cfg.gain = cfg_wdata_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i)
        predict_normalized(s_tuser_i, s_tdata_i[5:0], s_tdata_i[37:6]);
      if (m_tvalid_i && m_tready_i) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result item: normalized_out %h", m_tdata_i[31:0]);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (m_tdata_i[31:0] !== exp_r.value) begin
            $error("normalized_out expected %h actual %h", exp_r.value, m_tdata_i[31:0]);
            fail_count_o++;
          end
          if (m_tuser_i !== exp_r.kind) begin
            $error("kind_out expected %0d actual %0d", exp_r.kind, m_tuser_i);
            fail_count_o++;
          end
          if (m_tdata_i[37:32] !== exp_r.element) begin
            $error("element_out expected %0d actual %0d", exp_r.element, m_tdata_i[37:32]);
            fail_count_o++;
          end
        end
      end
    end
  end
endmodule

[tb/sv/tb_running_mean_variance_normalizer_core.sv]
// Stimulus and verdict for the running mean/variance normalizer core.
module tb_running_mean_variance_normalizer_core;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [39:0] s_axis_tdata_i = '0;   // [5:0] element_index, [37:6] sample_in, zero pad
  logic        s_axis_tuser_i = 1'b0; // [0] op
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [39:0] m_axis_tdata_o;        // [31:0] normalized_out, [37:32] element_out, zero pad
  logic        m_axis_tuser_o;        // [0] kind_out
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [24:0] cfg_wdata_i = '0;

  int fail_count, pending, send_idle, recv_stall, quiet_cycles;

  running_mean_variance_normalizer_core uut (.*);

  rmvn_monitor u_monitor (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_axis_tvalid_i), .s_tready_i(s_axis_tready_o),
    .s_tdata_i(s_axis_tdata_i), .s_tuser_i(s_axis_tuser_i),
    .m_tvalid_i(m_axis_tvalid_o), .m_tready_i(m_axis_tready_i),
    .m_tdata_i(m_axis_tdata_o), .m_tuser_i(m_axis_tuser_o),
    .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) m_axis_tready_i <= ($urandom_range(99) >= recv_stall);

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= 20000) begin
      $display("tb_running_mean_variance_normalizer_core: errors");
      $finish;
    end
  end

  task automatic send_item(logic op, logic [5:0] idx, logic [31:0] x);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i <= op;
    s_axis_tdata_i <= {2'b00, x, idx};
    do @(posedge clk_i); while (!s_axis_tready_o);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [24:0] value);
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] random_sample();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      2: return $urandom_range(32'h0100_0000) - 32'h0080_0000;
      default: return $urandom_range(32'h0000_4000) + 32'h0001_0000;
    endcase
  endfunction

  function automatic logic [24:0] random_smoothing();
    case ($urandom_range(4))
      0: return 25'd0;
      1: return 25'd65536;
      2: return 25'($urandom_range(25'h1FFFF));
      default: return 25'($urandom_range(12000, 1));
    endcase
  endfunction

  function automatic logic [24:0] random_gain();
    case ($urandom_range(4))
      0: return 25'd0;
      1: return 25'd16777216;
      2: return 25'($urandom_range(25'h1FF_FFFF));
      default: return 25'($urandom_range(25'd262144));
    endcase
  endfunction

  initial begin
    send_idle = 0;
    recv_stall = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // pass-through at reset settings
    send_item(1'b0, 6'd0, 32'h7FFF_FFFF);
    send_item(1'b0, 6'd63, 32'h8000_0000);
    send_item(1'b1, 6'd63, 32'h7FFF_FFFF);
    send_item(1'b1, 6'd0, 32'h8000_0000);
    send_item(1'b0, 6'd21, 32'h0000_0000);
    write_reg(3'd5, 25'h1FF_FFFF);
    write_reg(3'd7, 25'd0);
    write_reg(rmvn_pkg::REG_REW_GAIN, 25'd16777216);
    send_item(1'b1, 6'd5, 32'h0001_0000);
    send_item(1'b1, 6'd5, 32'hFFFF_0000);
    write_reg(rmvn_pkg::REG_OBS_EN, 25'd1);
    write_reg(rmvn_pkg::REG_REW_EN, 25'd1);
    write_reg(rmvn_pkg::REG_OBS_SMOOTH, 25'h1FFFF);
    write_reg(rmvn_pkg::REG_REW_SMOOTH, 25'd65536);
    // full weight drives the variance to zero, hence a zero root
    send_item(1'b0, 6'd3, 32'h0002_0000);
    send_item(1'b0, 6'd3, 32'h0002_0000);
    send_item(1'b1, 6'd0, 32'h0000_0001);
    send_item(1'b1, 6'd0, 32'h8000_0000);
    write_reg(rmvn_pkg::REG_REW_GAIN, 25'd0);
    send_item(1'b1, 6'd0, 32'h7FFF_FFFF);
    write_reg(rmvn_pkg::REG_OBS_SMOOTH, 25'd0);
    write_reg(rmvn_pkg::REG_REW_SMOOTH, 25'd66);
    write_reg(rmvn_pkg::REG_REW_GAIN, 25'd65536);
    send_item(1'b0, 6'd63, 32'h7FFF_FFFF);
    send_item(1'b0, 6'd0, 32'h8000_0000);
    send_item(1'b1, 6'd9, 32'h8000_0000);
    send_item(1'b1, 6'd9, 32'h0003_8000);

    for (int phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0: begin send_idle = 0;  recv_stall = 0;  end
        1: begin send_idle = 45; recv_stall = 0;  end
        2: begin send_idle = 0;  recv_stall = 45; end
        default: begin send_idle = 29; recv_stall = 29; end
      endcase
      write_reg(rmvn_pkg::REG_OBS_SMOOTH, random_smoothing());
      write_reg(rmvn_pkg::REG_REW_SMOOTH, random_smoothing());
      write_reg(rmvn_pkg::REG_OBS_EN,
                (phase == 5) ? 25'd0 : {24'($urandom_range(24'hFF_FFFF)), 1'b1});
      write_reg(rmvn_pkg::REG_REW_EN, (phase == 6) ? 25'h1FF_FFFE : 25'd1);
      write_reg(rmvn_pkg::REG_REW_GAIN, random_gain());
      for (int n = 0; n < 128; n++)
        send_item($urandom_range(3) == 0, 6'($urandom_range(63)), random_sample());
    end

    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    if (fail_count == 0 && pending == 0)
      $display("tb_running_mean_variance_normalizer_core: clean");
    else
      $display("tb_running_mean_variance_normalizer_core: errors");
    $finish;
  end
endmodule
